// ----- hw/rtl/context_window_weight_scorer_unit_defines.svh -----
// Assertion macros shared by the checker of the context window weight scorer.
`ifndef CONTEXT_WINDOW_WEIGHT_SCORER_UNIT_DEFINES_SVH
`define CONTEXT_WINDOW_WEIGHT_SCORER_UNIT_DEFINES_SVH

// Property must hold on every clock edge outside reset.
`define CWWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition must never be seen outside reset.
`define CWWS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ----- hw/rtl/cwws_pkg.sv -----
// Shared constants and controller/datapath interface types of the window scorer.
package cwws_pkg;

  // Residue alphabet; codes at or above it weigh zero
  localparam int unsigned ALPHABET = 20;

  // Field widths
  localparam int unsigned COL_W   = 4;
  localparam int unsigned RES_W   = 5;
  localparam int unsigned WGT_W   = 16;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned SCORE_W = 20;
  localparam int unsigned HW_W    = 3;

  // Width that holds column * ALPHABET + residue for any legal column
  localparam int unsigned ADDR_CALC_W = 9;

  // Reset value of the half window register
  localparam logic [HW_W-1:0] HALF_WINDOW_RST = 3'd6;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_weight;   // write one weight into the table
    logic load_residue;  // store residue in history and latch final flag
    logic start_score;   // set up the first score of this residue
    logic issue;         // read one window column
    logic emit;          // move finished score into the output register
    logic next_score;    // set up the next score of a flush
    logic finish;        // advance or clear the residue count
  } cwws_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic has_score;     // this residue produces at least one score
    logic fin;           // this residue ends the sequence
    logic col_last;      // current column is the last of the window
    logic offs_zero;     // current score is for the newest position
    logic out_free;      // output register can take a word this cycle
  } cwws_stat_t;

endpackage

// ----- hw/rtl/context_window_weight_scorer_unit.sv -----
// Top level of the context window weight scorer: controller plus datapath.
//
//  channel  dir  handshake                  payload
//  s_axis   in   s_axis_tvalid/tready       tdata: column, residue, weight
//                                           tuser: kind; tlast: final residue
//  m_axis   out  m_axis_tvalid/tready       tdata: position, score
//                                           tlast: last score of the run
//  cfg      in   cfg_we_i                   cfg_wdata_i: half window
//
// A weight word is taken while idle. A residue word is accepted and set up,
// then each score makes one weight table read per window column, over 2h+1
// columns with h the effective half window, one drain and one emit; a residue
// with no score ends after setup. The weight table has a single read port.
// Reset leaves the weight table unwritten; it must be loaded before scoring.
// A stalled output holds the emit cycle; input is refused while a residue
// is in work, and accepted while a finished score waits to be taken.
module context_window_weight_scorer_unit
  import cwws_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 13,
  parameter int unsigned MAX_LENGTH = 65536
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [31:0]      s_axis_tdata,   // column[3:0], residue[8:4], weight[24:9]
  input  logic             s_axis_tuser,   // kind
  input  logic             s_axis_tlast,   // final_residue
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // position[15:0], score[35:16]
  output logic             m_axis_tlast,   // last_of_run
  input  logic             cfg_we_i,
  input  logic [HW_W-1:0]  cfg_wdata_i
);

  cwws_cmd_t  cmd;
  cwws_stat_t stat;

  logic [POS_W-1:0]          out_position;
  logic signed [SCORE_W-1:0] out_score;

  cwws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cwws_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_column_i    (s_axis_tdata[3:0]),
    .in_residue_i   (s_axis_tdata[8:4]),
    .in_weight_i    ($signed(s_axis_tdata[24:9])),
    .in_final_i     (s_axis_tlast),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_ready_i    (m_axis_tready),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (m_axis_tvalid),
    .out_position_o (out_position),
    .out_score_o    (out_score),
    .out_last_o     (m_axis_tlast)
  );

  // Pack output word, zero fill to whole bytes
  assign m_axis_tdata = {4'b0000, out_score, out_position};

endmodule

// ----- hw/rtl/cwws_ctrl.sv -----
// Sequencing state machine of the window scorer.
module cwws_ctrl
  import cwws_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_kind_i,
  output logic       in_ready_o,
  input  cwws_stat_t stat_i,
  output cwws_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_kind_i) begin
            cmd_o.load_residue = 1'b1;
            state_d            = ST_START;
          end else begin
            cmd_o.load_weight = 1'b1;
          end
        end
      end
      ST_START: begin
        if (stat_i.has_score) begin
          cmd_o.start_score = 1'b1;
          state_d           = ST_ISSUE;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        if (stat_i.col_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.fin && !stat_i.offs_zero) begin
            cmd_o.next_score = 1'b1;
            state_d          = ST_ISSUE;
          end else begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/cwws_datapath.sv -----
// Weight table, residue history, window accumulator and output register.
module cwws_datapath
  import cwws_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 13,
  parameter int unsigned MAX_LENGTH = 65536
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [COL_W-1:0]          in_column_i,
  input  logic [RES_W-1:0]          in_residue_i,
  input  logic signed [WGT_W-1:0]   in_weight_i,
  input  logic                      in_final_i,
  input  logic                      cfg_we_i,
  input  logic [HW_W-1:0]           cfg_wdata_i,
  input  logic                      out_ready_i,
  input  cwws_cmd_t                 cmd_i,
  output cwws_stat_t                stat_o,
  output logic                      out_valid_o,
  output logic [POS_W-1:0]          out_position_o,
  output logic signed [SCORE_W-1:0] out_score_o,
  output logic                      out_last_o
);

  localparam int unsigned DEPTH = MAX_WINDOW * ALPHABET;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CW    = $clog2(MAX_LENGTH);
  localparam logic [HW_W-1:0] HMAX = HW_W'((MAX_WINDOW - 1) / 2);

  // Storage
  logic signed [WGT_W-1:0] wmem [DEPTH];
  logic [RES_W-1:0]        hist_q [MAX_WINDOW];

  logic [HW_W-1:0]         half_window_q;
  logic [CW-1:0]           count_q;
  logic [SW-1:0]           slot_q;
  logic                    fin_q;
  logic [HW_W-1:0]         offs_q;
  logic [COL_W-1:0]        col_q;
  logic                    rd_en_q;
  logic signed [WGT_W-1:0] mem_q;
  logic signed [SCORE_W-1:0] acc_q;

  logic                    out_valid_q;
  logic [POS_W-1:0]        out_pos_q;
  logic signed [SCORE_W-1:0] out_score_q;
  logic                    out_last_q;

  // Effective half window
  logic [HW_W-1:0] h_eff;
  assign h_eff = (half_window_q > HMAX) ? HMAX : half_window_q;

  // Weight write address and range check
  logic          wr_ok;
  logic [AW-1:0] waddr;
  assign wr_ok = (32'(in_column_i) < MAX_WINDOW) && (in_residue_i < RES_W'(ALPHABET));
  assign waddr = AW'(ADDR_CALC_W'(in_column_i) * ADDR_CALC_W'(ALPHABET)
                     + ADDR_CALC_W'(in_residue_i));

  // Distance back from the newest residue for the current column
  logic signed [5:0] lag;
  logic              col_ok;
  logic signed [5:0] lag_eff;
  logic signed [5:0] sdiff;
  logic signed [5:0] slot_rd;
  logic [RES_W-1:0]  res_rd;
  logic              res_ok;
  logic [AW-1:0]     raddr;

  always_comb begin
    lag      = $signed(6'(offs_q)) + $signed(6'(h_eff)) - $signed(6'(col_q));
    col_ok   = !lag[5] && (CW'($unsigned(lag)) <= count_q);
    lag_eff  = col_ok ? lag : 6'sd0;
    sdiff    = $signed(6'(slot_q)) - lag_eff;
    slot_rd  = sdiff[5] ? (sdiff + $signed(6'(MAX_WINDOW))) : sdiff;
    res_rd   = hist_q[SW'($unsigned(slot_rd))];
    res_ok   = col_ok && (res_rd < RES_W'(ALPHABET));
    raddr    = AW'(ADDR_CALC_W'(col_q) * ADDR_CALC_W'(ALPHABET)
                   + ADDR_CALC_W'(res_ok ? res_rd : '0));
  end

  // Status
  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    stat_o.has_score = fin_q || (count_q >= CW'(h_eff));
    stat_o.fin       = fin_q;
    stat_o.col_last  = (col_q == {h_eff, 1'b0});
    stat_o.offs_zero = (offs_q == '0);
    stat_o.out_free  = out_free;
  end

  // Weight table: written on loads, read one column per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_weight && wr_ok) begin
      wmem[waddr] <= in_weight_i;
    end
    if (cmd_i.issue) begin
      mem_q <= wmem[raddr];
    end
  end

  // Residue history
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_residue) begin
      hist_q[slot_q] <= in_residue_i;
    end
  end

  // Configuration, sequence bookkeeping and column sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_window_q <= HALF_WINDOW_RST;
      count_q       <= '0;
      slot_q        <= '0;
      fin_q         <= 1'b0;
      offs_q        <= '0;
      col_q         <= '0;
      rd_en_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        half_window_q <= cfg_wdata_i;
      end
      if (cmd_i.load_residue) begin
        fin_q <= in_final_i || (count_q == CW'(MAX_LENGTH - 1));
      end
      if (cmd_i.start_score) begin
        if (fin_q && (count_q < CW'(h_eff))) begin
          offs_q <= HW_W'(count_q);
        end else begin
          offs_q <= h_eff;
        end
        col_q <= '0;
      end else if (cmd_i.next_score) begin
        offs_q <= offs_q - 1'b1;
        col_q  <= '0;
      end else if (cmd_i.issue) begin
        col_q <= col_q + 1'b1;
      end
      rd_en_q <= cmd_i.issue && res_ok;
      if (cmd_i.finish) begin
        if (fin_q) begin
          count_q <= '0;
          slot_q  <= '0;
        end else begin
          count_q <= count_q + 1'b1;
          slot_q  <= (slot_q == SW'(MAX_WINDOW - 1)) ? '0 : slot_q + 1'b1;
        end
      end
    end
  end

  // Window accumulator
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_score || cmd_i.next_score) begin
      acc_q <= '0;
    end else if (rd_en_q) begin
      acc_q <= acc_q + SCORE_W'(mem_q);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_pos_q   <= POS_W'(count_q - CW'(offs_q));
      out_score_q <= acc_q;
      out_last_q  <= !fin_q || (offs_q == '0);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_position_o = out_pos_q;
  assign out_score_o    = out_score_q;
  assign out_last_o     = out_last_q;

endmodule

// ----- hw/rtl/cwws_checker.sv -----
// Port-level assertions for the context window weight scorer, bound to the top.
`include "context_window_weight_scorer_unit_defines.svh"

module cwws_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // Stalled output word holds
  `CWWS_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)), "output word changed under stall")

  // A residue word puts the block to work
  `CWWS_ASSERT(a_res_busy, (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> !s_axis_tready, "ready after residue word")

  // A weight word never blocks the input
  `CWWS_ASSERT(a_wgt_free, (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> s_axis_tready, "weight load stalled input")

  // A new score only leaves from a busy cycle
  `CWWS_ASSERT(a_emit_busy, $rose(m_axis_tvalid) |-> !$past(s_axis_tready), "score emitted while idle")

endmodule

bind context_window_weight_scorer_unit cwws_checker u_cwws_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- verif/tb.sv -----
// Self-checking testbench for the context window weight scorer.
`timescale 1ns / 100ps

module tb
  import cwws_pkg::*;
();

  localparam int unsigned WIN          = 13;
  localparam int unsigned SEQ_LIMIT    = 65536;
  localparam int unsigned WIN_H_MAX    = (WIN - 1) / 2;
  localparam int unsigned SETTLE       = 32;    // room for the slowest score plus setup
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RANDOM_ITEMS = 160;

  // One expected score word
  typedef struct packed {
    logic [POS_W-1:0]          pos;
    logic signed [SCORE_W-1:0] score;
    logic                      last;
  } score_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata  = '0;   // column[3:0], residue[8:4], weight[24:9]
  logic               s_axis_tuser  = 1'b0; // kind
  logic               s_axis_tlast  = 1'b0; // final_residue
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [39:0]        m_axis_tdata;         // position[15:0], score[35:16]
  logic               m_axis_tlast;         // last_of_run
  logic               cfg_we_i      = 1'b0;
  logic [HW_W-1:0]    cfg_wdata_i   = '0;

  // Scorer mirror: weight table, residue ring, count and half window
  logic signed [WGT_W-1:0] wgt_tab [WIN][ALPHABET];
  logic [RES_W-1:0]        res_ring [WIN];
  int unsigned             res_count = 0;
  logic [HW_W-1:0]         half_win  = HALF_WINDOW_RST;

  score_t pending_scores[$];
  score_t want;
  int     err_count = 0;

  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;
  bit hold_pending = 1'b0;

  context_window_weight_scorer_unit #(
    .MAX_WINDOW (WIN),
    .MAX_LENGTH (SEQ_LIMIT)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #30ms;
    $display("tb NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // Sum of the window weights around position p, residues 0..n present
  function automatic logic signed [SCORE_W-1:0] window_score(int unsigned p, int unsigned n,
                                                             int unsigned h);
    int unsigned      lo;
    int unsigned      hi;
    int               sum;
    logic [RES_W-1:0] r;
    lo  = (p >= h) ? p - h : 0;
    hi  = (p + h < n) ? p + h : n;
    sum = 0;
    for (int unsigned i = lo; i <= hi; i++) begin
      r = res_ring[i % WIN];
      // codes from 20 up mean any residue and weigh zero
      if (r < ALPHABET) sum += int'(wgt_tab[i + h - p][r]);
    end
    return sum[SCORE_W-1:0];
  endfunction

  // Update the mirror for one accepted word and queue the scores it causes
  function automatic void predict_word(bit kind, logic [COL_W-1:0] col, logic [RES_W-1:0] res,
                                       logic [WGT_W-1:0] wgt, bit fin);
    int unsigned h;
    int unsigned n;
    int unsigned first;
    score_t      s;
    if (!kind) begin
      // out-of-range loads are dropped
      if (col < WIN && res < ALPHABET) wgt_tab[col][res] = wgt;
      return;
    end
    h = (half_win > WIN_H_MAX) ? WIN_H_MAX : half_win;
    n = res_count;
    res_ring[n % WIN] = res;
    // overlong sequence ends on its own
    if (n >= SEQ_LIMIT - 1) fin = 1'b1;
    if (!fin) begin
      if (n >= h) begin
        s.pos   = POS_W'(n - h);
        s.score = window_score(n - h, n, h);
        s.last  = 1'b1;
        pending_scores = {pending_scores, s};
      end
      res_count = n + 1;
    end else begin
      // flush: every position still open, oldest first
      first = (n >= h) ? n - h : 0;
      for (int unsigned p = first; p <= n; p++) begin
        s.pos   = POS_W'(p);
        s.score = window_score(p, n, h);
        s.last  = (p == n);
        pending_scores = {pending_scores, s};
      end
      res_count = 0;
    end
  endfunction

  // Offer one input word and hold it until it is taken
  task automatic send_word(input bit kind, input logic [COL_W-1:0] col,
                           input logic [RES_W-1:0] res, input logic [WGT_W-1:0] wgt,
                           input bit fin);
    @(negedge clk_i);
    if (src_idle_en && $urandom_range(99) < 35) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, wgt, res, col};
    s_axis_tuser  <= kind;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_word(kind, col, res, wgt, fin);
  endtask

  // Residue word with random content in the fields it ignores
  task automatic send_residue(input logic [RES_W-1:0] res, input bit fin);
    send_word(1'b1, COL_W'($urandom), res, WGT_W'($urandom), fin);
  endtask

  function automatic logic [RES_W-1:0] pick_residue();
    if ($urandom_range(99) < 12) return RES_W'($urandom_range(ALPHABET, 31));
    return RES_W'($urandom_range(0, ALPHABET - 1));
  endfunction

  // Stop offering and let every expected score come out
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_half_window(input logic [HW_W-1:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    half_win = value;
  endtask

  // Receiver: random stalls, or a long counted hold when asked
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(sink_idle_en && $urandom_range(99) < 35);
      end
    end
  end

  // Score checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_scores.size() == 0) begin
        report_mismatch($sformatf("unexpected score word, pos %0d", m_axis_tdata[15:0]));
      end else begin
        want = pending_scores.pop_front();
        if (m_axis_tdata[15:0] !== want.pos)
          report_mismatch($sformatf("pos got %0d want %0d", m_axis_tdata[15:0], want.pos));
        if (m_axis_tdata[35:16] !== want.score)
          report_mismatch($sformatf("pos %0d: score got %0d want %0d", want.pos,
                                    $signed(m_axis_tdata[35:16]), want.score));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("pos %0d: last got %0b want %0b", want.pos,
                                    m_axis_tlast, want.last));
      end
    end
  end

  // Fill the whole table; residue 0 at the top, residue 1 at the bottom of the range
  task automatic test_table_load();
    logic [WGT_W-1:0] w;
    for (int c = 0; c < WIN; c++) begin
      for (int r = 0; r < ALPHABET; r++) begin
        if (r == 0)      w = 16'h7FFF;
        else if (r == 1) w = 16'h8000;
        else             w = WGT_W'($urandom);
        send_word(1'b0, COL_W'(c), RES_W'(r), w, 1'($urandom));
      end
    end
    // loads outside the table are dropped
    send_word(1'b0, 4'd15, 5'd5, 16'h7FFF, 1'b0);
    send_word(1'b0, 4'd3, 5'd31, 16'h8000, 1'b1);
    send_word(1'b0, 4'd13, 5'd20, 16'h1234, 1'b0);
  endtask

  // Reset half window: lone residue, full-scale sums, any-residue codes
  task automatic test_directed_sequences();
    send_residue(5'd7, 1'b1);
    for (int k = 0; k < WIN; k++) send_residue(5'd0, k == WIN - 1);
    for (int k = 0; k < WIN; k++) send_residue(5'd1, k == WIN - 1);
    send_residue(5'd20, 1'b0);
    send_residue(5'd31, 1'b0);
    send_residue(5'd19, 1'b1);
  endtask

  // Short sequences over the register range, saturation included
  task automatic test_half_window_range();
    logic [HW_W-1:0] settings [5] = '{3'd0, 3'd7, 3'd1, 3'd3, 3'd6};
    int unsigned     len;
    foreach (settings[i]) begin
      set_half_window(settings[i]);
      len = $urandom_range(3, 16);
      for (int unsigned k = 0; k < len; k++) send_residue(pick_residue(), k == len - 1);
    end
  endtask

  // Register and table change while a sequence is open
  task automatic test_mid_sequence_changes();
    set_half_window(3'd2);
    for (int k = 0; k < 6; k++) send_residue(pick_residue(), 1'b0);
    set_half_window(3'd5);
    send_residue(pick_residue(), 1'b0);
    send_word(1'b0, 4'd6, 5'd4, WGT_W'($urandom), 1'b0);
    send_word(1'b0, 4'd0, 5'd9, WGT_W'($urandom), 1'b1);
    for (int k = 0; k < 3; k++) send_residue(RES_W'($urandom_range(0, ALPHABET - 1)), 1'b0);
    set_half_window(3'd0);
    send_residue(pick_residue(), 1'b0);
    set_half_window(3'd4);
    send_residue(pick_residue(), 1'b1);
  endtask

  // Long receiver hold while the sender keeps offering, then a full drain
  task automatic test_output_hold();
    set_half_window(3'd6);
    hold_pending = 1'b1;
    for (int k = 0; k < 20; k++) send_residue(pick_residue(), k == 19);
    wait_idle();
    for (int k = 0; k < 8; k++) send_residue(pick_residue(), k == 7);
  endtask

  // Random sequences with weight loads sprinkled in
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned seq;
    int unsigned len;
    bit          quiet;
    sent = 0;
    seq  = 0;
    while (sent < RANDOM_ITEMS) begin
      if (seq % 5 == 0)              set_half_window(3'd7);
      else if ($urandom_range(1))    set_half_window(HW_W'($urandom_range(0, 7)));
      // a stretch of sequences with no idling on either side
      quiet        = (seq >= 4 && seq < 8);
      src_idle_en  = !quiet;
      sink_idle_en = !quiet;
      len = ($urandom_range(9) == 0) ? $urandom_range(16, 30) : $urandom_range(1, 12);
      for (int unsigned k = 0; k < len; k++) begin
        if ($urandom_range(99) < 8)
          send_word(1'b0, COL_W'($urandom), RES_W'($urandom), WGT_W'($urandom),
                    1'($urandom));
        send_residue(pick_residue(), k == len - 1);
        sent++;
      end
      seq++;
    end
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  // Test sequence
  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_table_load();
    test_directed_sequences();
    test_half_window_range();
    test_mid_sequence_changes();
    test_output_hold();
    test_random_traffic();
    wait_idle();
    if (err_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
